// ===== design/blpg_pkg.sv =====
// Package for the Bresenham line pixel generator.
// Holds the opcode type and the fixed colour width; no dependencies.
package blpg_pkg;

    // Operation carried by each input transfer.
    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // Width of an RGB565 colour word.
    localparam int COLOUR_BITS = 16;

endpackage

// ===== design/blpg_if.sv =====
// Valid/ready channel interfaces for the line pixel generator.
// Depends on blpg_pkg for the opcode type and the colour width.
interface blpg_in_if import blpg_pkg::*; #(
    parameter int COORD_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    t_opcode                opcode;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    logic [COLOUR_BITS-1:0] colour_in;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, colour_in,
                    input ready);
    modport sink (input valid, opcode, start_x, start_y, end_x, end_y, colour_in,
                  output ready);
endinterface

interface blpg_out_if import blpg_pkg::*; #(
    parameter int COORD_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic                   last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_colour, last_pixel,
                  output ready);
endinterface

// ===== design/bresenham_line_pixel_generator_top.sv =====
// Top level of the Bresenham line pixel generator.
// Depends on blpg_pkg and on the channel interfaces in blpg_if.sv.
//
// The block takes one input transfer per clock cycle unless ready is low. A load
// transfer sets up a line (major axis, endpoint order, minor step direction,
// decision term) and gives no result; each following step transfer emits one
// pixel into the output register, so a line of N pixels takes one load and N
// step transfers. The cycle time is set by the decision-term add and sign
// test that picks the minor step, and on load by the endpoint difference and
// compare chain. The input side drops ready only when a step would emit a pixel
// while the output register is full and stalled; loads and steps while idle are
// always taken. A load while a line is in progress replaces that line.
module bresenham_line_pixel_generator_top import blpg_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    blpg_in_if.sink       i_in,
    blpg_out_if.source    o_out
);

    localparam int CB       = COORD_BITS;
    localparam int DEC_BITS = COORD_BITS + 3;

    // Line state.
    logic                       r_busy;
    logic                       r_major_is_x;
    logic [CB-1:0]              r_major_pos;
    logic [CB-1:0]              r_major_stop;
    logic [CB-1:0]              r_minor_pos;
    logic                       r_minor_step_down;
    logic signed [DEC_BITS-1:0] r_decision;
    logic [CB:0]                r_twice_major_delta;
    logic [CB:0]                r_twice_minor_delta;
    logic [COLOUR_BITS-1:0]     r_line_colour;

    // Result register.
    logic                       r_out_valid;
    logic [CB-1:0]              r_pixel_x;
    logic [CB-1:0]              r_pixel_y;
    logic [COLOUR_BITS-1:0]     r_pixel_colour;
    logic                       r_last_pixel;

    // Handshake decode.
    logic in_fire;
    logic load_fire;
    logic emit_fire;
    logic out_free;

    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = out_free || (i_in.opcode == OP_LOAD) || !r_busy;
    assign in_fire   = i_in.valid && i_in.ready;
    assign load_fire = in_fire && (i_in.opcode == OP_LOAD);
    assign emit_fire = in_fire && (i_in.opcode == OP_STEP) && r_busy;

    // Line setup from the two endpoints.
    logic signed [CB:0]         dx;
    logic signed [CB:0]         dy;
    logic [CB-1:0]              adx;
    logic [CB-1:0]              ady;
    logic                       n_major_is_x;
    logic [CB-1:0]              maj0;
    logic [CB-1:0]              maj1;
    logic [CB-1:0]              min0;
    logic [CB-1:0]              min1;
    logic [CB-1:0]              dmaj;
    logic signed [CB:0]         dmin_s;
    logic [CB-1:0]              dmin;
    logic signed [DEC_BITS-1:0] n_load_decision;

    always_comb begin
        dx  = $signed({1'b0, i_in.end_x}) - $signed({1'b0, i_in.start_x});
        dy  = $signed({1'b0, i_in.end_y}) - $signed({1'b0, i_in.start_y});
        adx = dx[CB] ? CB'(-dx) : CB'(dx);
        ady = dy[CB] ? CB'(-dy) : CB'(dy);
        n_major_is_x = ady < adx;
        if (n_major_is_x) begin
            if (i_in.start_x > i_in.end_x) begin
                maj0 = i_in.end_x;   min0 = i_in.end_y;
                maj1 = i_in.start_x; min1 = i_in.start_y;
            end else begin
                maj0 = i_in.start_x; min0 = i_in.start_y;
                maj1 = i_in.end_x;   min1 = i_in.end_y;
            end
        end else begin
            if (i_in.start_y > i_in.end_y) begin
                maj0 = i_in.end_y;   min0 = i_in.end_x;
                maj1 = i_in.start_y; min1 = i_in.start_x;
            end else begin
                maj0 = i_in.start_y; min0 = i_in.start_x;
                maj1 = i_in.end_y;   min1 = i_in.end_x;
            end
        end
        dmaj   = maj1 - maj0;
        dmin_s = $signed({1'b0, min1}) - $signed({1'b0, min0});
        dmin   = dmin_s[CB] ? CB'(-dmin_s) : CB'(dmin_s);
        n_load_decision = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
    end

    // One Bresenham step on the kept state.
    logic                       step_last;
    logic                       step_minor;
    logic signed [DEC_BITS-1:0] n_step_decision;
    logic [CB-1:0]              n_minor_pos;

    always_comb begin
        step_last  = r_major_pos == r_major_stop;
        step_minor = !r_decision[DEC_BITS-1] && (r_decision != '0);
        n_step_decision = r_decision + $signed({2'b00, r_twice_minor_delta})
                          - (step_minor ? $signed({2'b00, r_twice_major_delta})
                                        : $signed(DEC_BITS'(0)));
        if (!step_minor) begin
            n_minor_pos = r_minor_pos;
        end else if (r_minor_step_down) begin
            n_minor_pos = r_minor_pos - CB'(1);
        end else begin
            n_minor_pos = r_minor_pos + CB'(1);
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy              <= 1'b0;
            r_major_is_x        <= 1'b0;
            r_major_pos         <= '0;
            r_major_stop        <= '0;
            r_minor_pos         <= '0;
            r_minor_step_down   <= 1'b0;
            r_decision          <= '0;
            r_twice_major_delta <= '0;
            r_twice_minor_delta <= '0;
            r_line_colour       <= '0;
        end else if (load_fire) begin
            r_busy              <= 1'b1;
            r_major_is_x        <= n_major_is_x;
            r_major_pos         <= maj0;
            r_major_stop        <= maj1;
            r_minor_pos         <= min0;
            r_minor_step_down   <= dmin_s[CB];
            r_decision          <= n_load_decision;
            r_twice_major_delta <= {dmaj, 1'b0};
            r_twice_minor_delta <= {dmin, 1'b0};
            r_line_colour       <= i_in.colour_in;
        end else if (emit_fire) begin
            r_major_pos <= r_major_pos + CB'(1);
            r_minor_pos <= n_minor_pos;
            r_decision  <= n_step_decision;
            if (step_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_pixel_x      <= r_major_is_x ? r_major_pos : r_minor_pos;
            r_pixel_y      <= r_major_is_x ? r_minor_pos : r_major_pos;
            r_pixel_colour <= r_line_colour;
            r_last_pixel   <= step_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pixel_x      = r_pixel_x;
    assign o_out.pixel_y      = r_pixel_y;
    assign o_out.pixel_colour = r_pixel_colour;
    assign o_out.last_pixel   = r_last_pixel;

    // A load always leaves a line in progress.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_fire |=> r_busy)
        else $error("line not busy after load");

    // The final pixel of a line returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && step_last) |=> !r_busy)
        else $error("still busy after final pixel");

    // The major coordinate never passes its stop during a line.
    a_major_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_major_pos <= r_major_stop))
        else $error("major coordinate passed its stop");

    // Input backpressure only comes from a full, stalled result register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready && r_busy))
        else $error("input stalled without cause");

endmodule

// ===== test/tb_bresenham_line_pixel_generator_top.sv =====
// Self-checking testbench for the Bresenham line pixel generator top level.
// Depends on blpg_pkg, the channel interfaces in blpg_if.sv and the top module;
// drives load and step transfers and checks every pixel against a line predictor.
`timescale 1ns / 100ps

module tb_bresenham_line_pixel_generator_top;
    import blpg_pkg::*;

    localparam int COORD_BITS   = 10;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int ITEM_TARGET  = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [COORD_BITS-1:0]  t_coord;
    typedef logic [COLOUR_BITS-1:0] t_colour;

    typedef struct {
        t_coord  x;
        t_coord  y;
        t_colour colour;
        logic    last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    blpg_in_if  #(.COORD_BITS(COORD_BITS)) in_if ();
    blpg_out_if #(.COORD_BITS(COORD_BITS)) out_if ();

    bresenham_line_pixel_generator_top #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Line predictor state.
    logic    line_busy;
    logic    line_major_x;
    t_coord  major_pos;
    t_coord  major_stop;
    t_coord  minor_pos;
    logic    minor_step_down;
    int      decision;
    int      twice_major;
    int      twice_minor;
    t_colour line_colour;

    t_pixel pending_pixels[$];

    int err_count;
    int load_count;
    int step_count;
    int useful_items;
    int pixels_checked;
    int stall_cycles;
    int cycle_count;
    int burst_left;
    int hold_cycles;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: the run fails if it goes on past the cycle limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_bresenham_line_pixel_generator_top: errors");
        $finish;
    end

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_coord clamp_coord(int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        return t_coord'(v);
    endfunction

    // Sets up a new line: major axis, endpoint order, minor direction and decision term.
    task automatic plan_line(t_coord sx, t_coord sy, t_coord ex, t_coord ey, t_colour col);
        int dx;
        int dy;
        int dmaj;
        int dmin;
        t_coord maj0;
        t_coord min0;
        t_coord maj1;
        t_coord min1;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        line_major_x = iabs(dy) < iabs(dx);
        if (line_major_x) begin
            if (sx > ex) begin
                maj0 = ex; min0 = ey; maj1 = sx; min1 = sy;
            end else begin
                maj0 = sx; min0 = sy; maj1 = ex; min1 = ey;
            end
        end else begin
            if (sy > ey) begin
                maj0 = ey; min0 = ex; maj1 = sy; min1 = sx;
            end else begin
                maj0 = sy; min0 = sx; maj1 = ey; min1 = ex;
            end
        end
        dmaj = int'(maj1) - int'(maj0);
        dmin = int'(min1) - int'(min0);
        minor_step_down = dmin < 0;
        dmin = iabs(dmin);
        major_pos   = maj0;
        major_stop  = maj1;
        minor_pos   = min0;
        twice_major = 2 * dmaj;
        twice_minor = 2 * dmin;
        decision    = 2 * dmin - dmaj;
        line_colour = col;
        line_busy   = 1'b1;
    endtask

    // Emits the next pixel of the current line and advances the decision term.
    task automatic next_pixel();
        t_pixel px;
        px.last   = (major_pos == major_stop);
        px.x      = line_major_x ? major_pos : minor_pos;
        px.y      = line_major_x ? minor_pos : major_pos;
        px.colour = line_colour;
        if (decision > 0) begin
            minor_pos = minor_step_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
            decision  = decision - twice_major;
        end
        decision  = decision + twice_minor;
        major_pos = major_pos + 1'b1;
        if (px.last) begin
            line_busy = 1'b0;
        end
        pending_pixels.push_back(px);
    endtask

    // Sender pacing: bursts of random length, most of them followed by a random gap.
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Offers one transfer, waits until it is taken and updates the predictor.
    task automatic send_item(t_opcode op, t_coord sx, t_coord sy, t_coord ex, t_coord ey,
                             t_colour col);
        in_if.valid     <= 1'b1;
        in_if.opcode    <= op;
        in_if.start_x   <= sx;
        in_if.start_y   <= sy;
        in_if.end_x     <= ex;
        in_if.end_y     <= ey;
        in_if.colour_in <= col;
        do @(posedge i_clk); while (!in_if.ready);
        if (op == OP_LOAD) begin
            load_count++;
            useful_items++;
            plan_line(sx, sy, ex, ey, col);
        end else begin
            step_count++;
            if (line_busy) begin
                useful_items++;
                next_pixel();
            end
        end
        pace_sender();
    endtask

    // Step transfer; the coordinate and colour fields carry noise that must be ignored.
    task automatic send_step();
        send_item(OP_STEP, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_colour'($urandom));
    endtask

    task automatic send_steps(int n);
        repeat (n) send_step();
    endtask

    // Receiver: ready follows one of four patterns picked at random, and a
    // requested hold-off keeps it low for a long stretch.
    initial begin
        int rx_mode;
        int phase;
        rx_mode = 0;
        phase   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase % 64 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        out_if.ready <= 1'b1;
                    end
                    1: begin
                        out_if.ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        out_if.ready <= (phase % 3 != 0);
                    end
                    default: begin
                        out_if.ready <= ($urandom_range(0, 9) < 4);
                    end
                endcase
            end
        end
    end

    // Result checker: each pixel transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && in_if.valid && !in_if.ready) begin
            stall_cycles++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", out_if.pixel_x, out_if.pixel_y);
                err_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                pixels_checked++;
                if (out_if.pixel_x !== exp_px.x) begin
                    $error("pixel_x: expected %0d, got %0d", exp_px.x, out_if.pixel_x);
                    err_count++;
                end
                if (out_if.pixel_y !== exp_px.y) begin
                    $error("pixel_y: expected %0d, got %0d", exp_px.y, out_if.pixel_y);
                    err_count++;
                end
                if (out_if.pixel_colour !== exp_px.colour) begin
                    $error("pixel_colour: expected %h, got %h", exp_px.colour,
                           out_if.pixel_colour);
                    err_count++;
                end
                if (out_if.last_pixel !== exp_px.last) begin
                    $error("last_pixel: expected %0d, got %0d", exp_px.last,
                           out_if.last_pixel);
                    err_count++;
                end
            end
        end
    end

    // Steps with no line loaded must give nothing.
    task automatic test_idle_steps();
        send_steps(2);
    endtask

    // Both endpoints equal: one pixel marked last, then an idle step.
    task automatic test_single_point();
        send_item(OP_LOAD, 10'd512, 10'd512, 10'd512, 10'd512, 16'hFFFF);
        send_steps(2);
    endtask

    // Reversed endpoints on each major axis, both with a falling minor coordinate,
    // plus a diagonal where the tie goes to y.
    task automatic test_orientations();
        send_item(OP_LOAD, 10'd1023, 10'd0, 10'd1020, 10'd2, 16'h0000);
        send_steps(4);
        send_item(OP_LOAD, 10'd0, 10'd1023, 10'd2, 10'd1020, 16'hA5A5);
        send_steps(4);
        send_item(OP_LOAD, 10'd0, 10'd0, 10'd2, 10'd2, 16'h1234);
        send_steps(3);
    endtask

    // A load while a line is in progress replaces it.
    task automatic test_reload_while_busy();
        send_item(OP_LOAD, 10'd0, 10'd0, 10'd1023, 10'd1023, 16'h5A5A);
        send_steps(2);
        send_item(OP_LOAD, 10'd1023, 10'd0, 10'd0, 10'd1023, 16'hFFFF);
        send_step();
    endtask

    // The receiver holds off for a long stretch while a line is being stepped,
    // so the output fills and the input stalls.
    task automatic test_output_backpressure();
        hold_cycles = 300;
        send_item(OP_LOAD, 10'd100, 10'd200, 10'd139, 10'd215, t_colour'($urandom));
        send_steps(40);
    endtask

    // Mostly whole short lines with random content; some long lines cut short,
    // some truncated sequences, stray steps and an occasional step past the end.
    task automatic test_random_lines();
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        int len;
        int n_steps;
        logic long_line;
        while (useful_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                send_step();
            end else begin
                long_line = ($urandom_range(0, 14) == 0);
                sx = t_coord'($urandom);
                sy = t_coord'($urandom);
                if (long_line) begin
                    ex = t_coord'($urandom);
                    ey = t_coord'($urandom);
                end else begin
                    ex = clamp_coord(int'(sx) + int'($urandom_range(0, 24)) - 12);
                    ey = clamp_coord(int'(sy) + int'($urandom_range(0, 24)) - 12);
                end
                send_item(OP_LOAD, sx, sy, ex, ey, t_colour'($urandom));
                len = iabs(int'(ex) - int'(sx));
                if (iabs(int'(ey) - int'(sy)) > len) begin
                    len = iabs(int'(ey) - int'(sy));
                end
                len = len + 1;
                n_steps = len;
                if (n_steps > 60) begin
                    n_steps = $urandom_range(20, 60);
                end
                if ($urandom_range(0, 7) == 0) begin
                    n_steps = $urandom_range(0, n_steps - 1);
                end else if ($urandom_range(0, 9) == 0) begin
                    n_steps = n_steps + 1;
                end
                send_steps(n_steps);
            end
        end
    endtask

    // Main sequence.
    initial begin
        err_count      = 0;
        load_count     = 0;
        step_count     = 0;
        useful_items   = 0;
        pixels_checked = 0;
        stall_cycles   = 0;
        burst_left     = 1;
        hold_cycles    = 0;

        line_busy       = 1'b0;
        line_major_x    = 1'b0;
        major_pos       = '0;
        major_stop      = '0;
        minor_pos       = '0;
        minor_step_down = 1'b0;
        decision        = 0;
        twice_major     = 0;
        twice_minor     = 0;
        line_colour     = '0;

        in_if.valid     = 1'b0;
        in_if.opcode    = OP_LOAD;
        in_if.start_x   = '0;
        in_if.start_y   = '0;
        in_if.end_x     = '0;
        in_if.end_y     = '0;
        in_if.colour_in = '0;
        i_rst_n         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_steps();
        test_single_point();
        test_orientations();
        test_reload_while_busy();
        test_output_backpressure();
        test_random_lines();

        // Drain the remaining pixels, then give the block a few more cycles.
        in_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and %0d steps; checked %0d pixels.", load_count,
                 step_count, pixels_checked);
        $display("Input was held off for %0d cycles by output backpressure.", stall_cycles);
        if (err_count == 0 && pending_pixels.size() == 0) begin
            $display("tb_bresenham_line_pixel_generator_top: clean");
        end else begin
            $display("tb_bresenham_line_pixel_generator_top: errors");
        end
        $finish;
    end

endmodule
